// File: rtl/core/pva_pkg.sv
`timescale 1ns / 1ps

package pva_pkg;

  // Sine ROM geometry (power of two, 64..4096)
  localparam int unsigned SINE_DEPTH = 1024;
  localparam int unsigned IDXW       = $clog2(SINE_DEPTH);
  localparam int unsigned QS_N       = SINE_DEPTH / 4 + 1;
  localparam int unsigned QS_AW      = IDXW - 1;
  localparam int unsigned FRAC_SH    = 16 - IDXW;

  localparam logic [16:0] FRAC_ONE = 17'h10000;
  localparam logic [4:0]  DIV_LAST = 5'd15;
  localparam logic [4:0]  MUL_LAST = 5'd16;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_ONE     = 64'd1073741824;

  // APB
  localparam int unsigned ADDR_W = 5;
  localparam logic [2:0] REG_START  = 3'd0;
  localparam logic [2:0] REG_END    = 3'd1;
  localparam logic [2:0] REG_PERIOD = 3'd2;
  localparam logic [2:0] REG_MODE   = 3'd3;
  localparam logic [2:0] REG_ENABLE = 3'd4;

  localparam logic [1:0] MODE_SINE   = 2'd1;
  localparam logic [1:0] MODE_COSINE = 2'd2;

  typedef struct packed {
    logic [31:0] start_value;
    logic [31:0] end_value;
    logic [15:0] period_ms;
    logic [1:0]  wave_mode;
    logic        cycle_enable;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mul_load;
    logic mul_step;
    logic finish;
    logic hold;
  } cmd_t;

  typedef struct packed {
    logic hit;
  } status_t;

  typedef logic [QS_N-1:0][16:0] qs_tab_t;

  // quarter-wave table: entry j = sin(pi/2 * j / (depth/4)) in Q16
  function automatic qs_tab_t qs_build();
    qs_tab_t tab;
    longint unsigned a;
    longint unsigned a2;
    longint unsigned t;
    tab = '0;
    for (int j = 0; j < QS_N; j++) begin
      a  = (HALF_PI_Q30 * 64'(j)) >> (IDXW - 2);
      a2 = (a * a) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - (((a2 * t) >> 30) / 64'd156);
      t  = Q30_ONE - (((a2 * t) >> 30) / 64'd110);
      t  = Q30_ONE - (((a2 * t) >> 30) / 64'd72);
      t  = Q30_ONE - (((a2 * t) >> 30) / 64'd42);
      t  = Q30_ONE - (((a2 * t) >> 30) / 64'd20);
      t  = Q30_ONE - (((a2 * t) >> 30) / 64'd6);
      tab[j] = 17'((((a * t) >> 30) + 64'd8192) >> 14);
    end
    return tab;
  endfunction

  localparam qs_tab_t QsTab = qs_build();

endpackage

// File: rtl/core/periodic_value_animator_top.sv
// Sequence: when animating, each input beat is loaded, then runs 16 divide
// steps, table select, 17 multiply steps and finish; when the tick reaches
// the period end the divide is skipped; when disabled the beat goes straight to finish.
// Flow: one beat in flight at a time, worked by the serial divider and the
// shift-add multiplier; next beat taken while a result waits.
// Reset: async active low; config registers 0, phase 0, ramp direction rising.
`timescale 1ns / 1ps

module periodic_value_animator_top import pva_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        elapsed_ms_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] current_value_o,
  output logic               period_wrapped_o
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  pva_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pva_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cycle_enable_i (cfg.cycle_enable),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  pva_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .status_o         (status),
    .elapsed_ms_i     (elapsed_ms_i),
    .current_value_o  (current_value_o),
    .period_wrapped_o (period_wrapped_o)
  );

endmodule

// File: rtl/core/pva_apb_regs.sv
`timescale 1ns / 1ps

module pva_apb_regs import pva_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[4:2])
        REG_START:  cfg_d.start_value  = pwdata;
        REG_END:    cfg_d.end_value    = pwdata;
        REG_PERIOD: cfg_d.period_ms    = pwdata[15:0];
        REG_MODE:   cfg_d.wave_mode    = pwdata[1:0];
        REG_ENABLE: cfg_d.cycle_enable = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_START:  prdata = cfg_q.start_value;
      REG_END:    prdata = cfg_q.end_value;
      REG_PERIOD: prdata = {16'd0, cfg_q.period_ms};
      REG_MODE:   prdata = {30'd0, cfg_q.wave_mode};
      REG_ENABLE: prdata = {31'd0, cfg_q.cycle_enable};
      default:    prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/pva_ctrl.sv
`timescale 1ns / 1ps

module pva_ctrl import pva_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  logic    cycle_enable_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SEL  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       hold_q, hold_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    hold_d      = hold_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.hold  = hold_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          hold_d     = !cycle_enable_i;
          cnt_d      = '0;
          state_d    = cycle_enable_i ? S_DIV : S_FIN;
        end
      end
      S_DIV: begin
        if (status_i.hit) begin
          state_d = S_SEL;
        end else begin
          cmd_o.div_step = 1'b1;
          cnt_d          = cnt_q + 5'd1;
          if (cnt_q == DIV_LAST) begin
            state_d = S_SEL;
          end
        end
      end
      S_SEL: begin
        cmd_o.mul_load = 1'b1;
        cnt_d          = '0;
        state_d        = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        cnt_d          = cnt_q + 5'd1;
        if (cnt_q == MUL_LAST) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      hold_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      hold_q      <= hold_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("accepted a beat while busy");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before taken");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV || state_q == S_MUL) |-> cnt_q <= MUL_LAST)
    else $error("step counter out of range");

endmodule

// File: rtl/core/pva_dp.sv
`timescale 1ns / 1ps

module pva_dp import pva_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic [15:0]        elapsed_ms_i,
  output logic signed [31:0] current_value_o,
  output logic               period_wrapped_o
);

  logic [15:0] phase_q;
  logic        rising_q;
  logic [15:0] t_q;
  logic [15:0] rem_q;
  logic [16:0] quo_q;
  logic [16:0] mul_q;
  logic [49:0] addend_q;
  logic [49:0] prod_q;
  logic [31:0] value_q;
  logic        wrapped_q;

  logic [16:0] sum;
  logic [15:0] t_new;
  logic [16:0] rem_sh;
  logic        q_bit;
  logic        is_sine;
  logic [IDXW-1:0]  idx;
  logic [1:0]       quad;
  logic [QS_AW-1:0] j_idx;
  logic [QS_AW-1:0] qs_addr;
  logic [16:0]      qs_val;
  logic [17:0]      biased;
  logic [16:0]      mix;
  logic [32:0]      span;
  logic [34:0]      s35, e35, p35, val;
  logic [31:0]      sat_val;
  logic             hit;

  // phase clamp
  assign sum   = {1'b0, phase_q} + {1'b0, elapsed_ms_i};
  assign t_new = (sum >= {1'b0, cfg_i.period_ms}) ? cfg_i.period_ms : sum[15:0];
  assign hit   = (t_q == cfg_i.period_ms);
  assign status_o.hit = hit;

  // restoring divide step
  assign rem_sh = {rem_q, 1'b0};
  assign q_bit  = (rem_sh >= {1'b0, cfg_i.period_ms});

  // sine lookup
  assign is_sine = (cfg_i.wave_mode == MODE_SINE) || (cfg_i.wave_mode == MODE_COSINE);
  assign idx     = quo_q[15:FRAC_SH]
                 + ((cfg_i.wave_mode == MODE_COSINE) ? IDXW'(SINE_DEPTH / 4) : '0);
  assign quad    = idx[IDXW-1:IDXW-2];
  assign j_idx   = {1'b0, idx[IDXW-3:0]};
  assign qs_addr = quad[0] ? (QS_AW'(SINE_DEPTH / 4) - j_idx) : j_idx;
  assign qs_val  = QsTab[qs_addr];
  // (wave + 1) in Q16, always non-negative
  assign biased  = quad[1] ? (18'h10000 - {1'b0, qs_val}) : (18'h10000 + {1'b0, qs_val});
  assign mix     = biased[17:1];

  assign span = {cfg_i.end_value[31], cfg_i.end_value}
              - {cfg_i.start_value[31], cfg_i.start_value};

  // combine and saturate
  assign s35 = {{3{cfg_i.start_value[31]}}, cfg_i.start_value};
  assign e35 = {{3{cfg_i.end_value[31]}}, cfg_i.end_value};
  assign p35 = {prod_q[49], prod_q[49:16]};
  assign val = (is_sine || rising_q) ? (s35 + p35) : (e35 - p35);

  always_comb begin
    if (val[34:31] == 4'b0000 || val[34:31] == 4'b1111) begin
      sat_val = val[31:0];
    end else begin
      sat_val = val[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      rising_q <= 1'b1;
    end else if (cmd_i.finish && !cmd_i.hold) begin
      phase_q  <= hit ? 16'd0 : t_q;
      rising_q <= rising_q ^ hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      t_q   <= t_new;
      rem_q <= t_new;
      quo_q <= (t_new == cfg_i.period_ms) ? FRAC_ONE : 17'd0;
    end else if (cmd_i.div_step) begin
      rem_q <= q_bit ? 16'(rem_sh - {1'b0, cfg_i.period_ms}) : rem_sh[15:0];
      quo_q <= {quo_q[15:0], q_bit};
    end

    if (cmd_i.mul_load) begin
      mul_q    <= is_sine ? mix : quo_q;
      addend_q <= {{17{span[32]}}, span};
      prod_q   <= '0;
    end else if (cmd_i.mul_step) begin
      if (mul_q[0]) begin
        prod_q <= prod_q + addend_q;
      end
      addend_q <= {addend_q[48:0], 1'b0};
      mul_q    <= {1'b0, mul_q[16:1]};
    end

    if (cmd_i.finish) begin
      value_q   <= cmd_i.hold ? cfg_i.start_value : sat_val;
      wrapped_q <= !cmd_i.hold && hit;
    end
  end

  assign current_value_o  = value_q;
  assign period_wrapped_o = wrapped_q;

  a_rem_below_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> rem_q < cfg_i.period_ms)
    else $error("divider remainder not below period");

endmodule
